### hdl/w2s_pkg.sv
`default_nettype none
package w2s_pkg;

  // Input word: one world point, signed Q16.16
  typedef struct packed {
    logic signed [31:0] pos_z;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_x;
  } in_word_t;

  // Result word: screen position in signed Q25.7
  typedef struct packed {
    logic               behind_camera;
    logic signed [31:0] screen_y;
    logic signed [31:0] screen_x;
  } out_word_t;

  // Register indexes of the configuration port
  typedef enum logic [2:0] {
    REG_MATRIX_COL0   = 3'd0,
    REG_MATRIX_COL1   = 3'd1,
    REG_MATRIX_COL2   = 3'd2,
    REG_TRANSLATE_XY  = 3'd3,
    REG_TRANSLATE_ZW  = 3'd4,
    REG_SCREEN_SIZE   = 3'd5,
    REG_NEAR_THRESH   = 3'd6
  } reg_index_t;

  // Clip sums carry 29 fraction bits and stay below 2^48 in magnitude
  localparam int CLIP_W = 50;
  localparam int MAG_W  = 49;
  // Quotient bits worked out; larger quotients saturate in any case
  localparam int DIV_BITS = 34;
  // Scaled dividend: 49-bit magnitude x 16-bit size x 128
  localparam int NUM_W  = 72;

endpackage
`default_nettype wire

### hdl/w2s_div.sv
`default_nettype none
// Pipelined restoring divider, one quotient bit per stage.
// The remainder entering is already below the divisor.
module w2s_div (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic [w2s_pkg::MAG_W-1:0]         rem_in,
  input  wire logic [w2s_pkg::DIV_BITS-1:0]      low_in,
  input  wire logic [w2s_pkg::MAG_W-1:0]         den_in,
  input  wire logic                              ovf_in,
  output logic      [w2s_pkg::DIV_BITS-1:0]      quo,
  output logic                                   ovf
);

  localparam int N = w2s_pkg::DIV_BITS;
  localparam int M = w2s_pkg::MAG_W;

  logic [M-1:0] rem_s [N];
  logic [N-1:0] low_s [N];
  logic [M-1:0] den_s [N];
  logic [N-1:0] quo_s [N];
  logic         ovf_s [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [M-1:0] rem_prev;
    logic [N-1:0] low_prev;
    logic [M-1:0] den_prev;
    logic [N-1:0] quo_prev;
    logic         ovf_prev;
    logic [M:0]   trial;
    logic [M:0]   diff;
    logic         ge;

    if (k == 0) begin : g_first
      assign rem_prev = rem_in;
      assign low_prev = low_in;
      assign den_prev = den_in;
      assign quo_prev = '0;
      assign ovf_prev = ovf_in;
    end else begin : g_next
      assign rem_prev = rem_s[k-1];
      assign low_prev = low_s[k-1];
      assign den_prev = den_s[k-1];
      assign quo_prev = quo_s[k-1];
      assign ovf_prev = ovf_s[k-1];
    end

    // shift in the next dividend bit and try the subtract
    assign trial = {rem_prev, low_prev[N-1]};
    assign diff  = trial - {1'b0, den_prev};
    assign ge    = (trial >= {1'b0, den_prev});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k] <= ge ? diff[M-1:0] : trial[M-1:0];
        low_s[k] <= {low_prev[N-2:0], 1'b0};
        den_s[k] <= den_prev;
        quo_s[k] <= {quo_prev[N-2:0], ge};
        ovf_s[k] <= ovf_prev;
      end
    end
  end

  assign quo = quo_s[N-1];
  assign ovf = ovf_s[N-1];

endmodule
`default_nettype wire

### hdl/world_to_screen_projection_core.sv
`default_nettype none
// World-to-screen projection core.
// Input channel in_valid/in_stall/in_word carries one world point (x, y, z)
// in signed Q16.16 per word. Output channel out_valid/out_stall/out_word
// returns one word per point: screen x and y in signed Q25.7, saturated, and
// a behind_camera flag (coordinates zero) when clip w is under the near
// threshold or not positive.
// Registers are written through cfg_we/cfg_index/cfg_data, one per cycle,
// and should only change while no point is in flight.
// From input acceptance to the output word, a point passes the matrix product,
// clip-sum, near-test and scaled-dividend stages, the bit-per-stage divider
// and a final stage for the viewport add and saturation; the divider stages
// set the depth. Throughput is one point per cycle unless the output stalls.
// Reset empties the pipeline and loads register defaults (z translation 1.0,
// w translation zero, near threshold 0.05, zero matrix and viewport).
// When the receiver stalls a valid output word, the whole pipeline holds
// and in_stall rises in the same cycle; nothing is dropped or repeated.
module world_to_screen_projection_core (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire w2s_pkg::in_word_t    in_word,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output w2s_pkg::out_word_t        out_word,
  input  wire logic                 cfg_we,
  input  wire logic [2:0]           cfg_index,
  input  wire logic [63:0]          cfg_data
);

  localparam int CW = w2s_pkg::CLIP_W;
  localparam int MW = w2s_pkg::MAG_W;
  localparam int DB = w2s_pkg::DIV_BITS;
  localparam int NW = w2s_pkg::NUM_W;

  // configuration registers
  logic [63:0] matrix_col0, matrix_col1, matrix_col2;
  logic [63:0] translate_xy, translate_zw;
  logic [31:0] screen_size;
  logic [30:0] near_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_col0    <= '0;
      matrix_col1    <= '0;
      matrix_col2    <= '0;
      translate_xy   <= '0;
      translate_zw   <= 64'd65536;
      screen_size    <= '0;
      near_threshold <= 31'd3277;
    end else if (cfg_we) begin
      case (cfg_index)
        w2s_pkg::REG_MATRIX_COL0:  matrix_col0    <= cfg_data;
        w2s_pkg::REG_MATRIX_COL1:  matrix_col1    <= cfg_data;
        w2s_pkg::REG_MATRIX_COL2:  matrix_col2    <= cfg_data;
        w2s_pkg::REG_TRANSLATE_XY: translate_xy   <= cfg_data;
        w2s_pkg::REG_TRANSLATE_ZW: translate_zw   <= cfg_data;
        w2s_pkg::REG_SCREEN_SIZE:  screen_size    <= cfg_data[31:0];
        w2s_pkg::REG_NEAR_THRESH:  near_threshold <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  logic [15:0] size_w, size_h;
  assign size_w = screen_size[15:0];
  assign size_h = screen_size[31:16];

  // whole pipeline advances unless a finished word is held
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage 1: the nine products needed for rows x, y and w
  logic               v1;
  logic signed [47:0] p1 [3][3];   // [row x/y/w][column]

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  for (genvar r = 0; r < 3; r++) begin : g_row
    localparam int ROW = (r == 2) ? 3 : r;
    always_ff @(posedge clk) begin
      if (en) begin
        p1[r][0] <= in_word.pos_x * $signed(matrix_col0[16*ROW +: 16]);
        p1[r][1] <= in_word.pos_y * $signed(matrix_col1[16*ROW +: 16]);
        p1[r][2] <= in_word.pos_z * $signed(matrix_col2[16*ROW +: 16]);
      end
    end
  end

  // stage 2: clip sums with the translation moved to 29 fraction bits
  logic                 v2;
  logic signed [CW-1:0] clip_x, clip_y, clip_w;
  logic signed [CW-1:0] tr_x, tr_y, tr_w;

  assign tr_x = CW'($signed({translate_xy[31:0],  13'b0}));
  assign tr_y = CW'($signed({translate_xy[63:32], 13'b0}));
  assign tr_w = CW'($signed({translate_zw[63:32], 13'b0}));

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      clip_x <= CW'(p1[0][0]) + CW'(p1[0][1]) + CW'(p1[0][2]) + tr_x;
      clip_y <= CW'(p1[1][0]) + CW'(p1[1][1]) + CW'(p1[1][2]) + tr_y;
      clip_w <= CW'(p1[2][0]) + CW'(p1[2][1]) + CW'(p1[2][2]) + tr_w;
    end
  end

  // stage 3: near test, magnitudes and the size partial products
  logic                 v3, behind3, neg_x3, neg_y3;
  logic [MW-1:0]        den3;
  logic [47:0]          px_lo, py_lo;
  logic [32:0]          px_hi, py_hi;
  logic [MW-1:0]        mag_x, mag_y;
  logic signed [CW-1:0] thr;
  logic [CW-1:0]        abs_x, abs_y;

  assign thr   = CW'({1'b0, near_threshold, 13'b0});
  assign abs_x = clip_x[CW-1] ? CW'(-clip_x) : CW'(clip_x);
  assign abs_y = clip_y[CW-1] ? CW'(-clip_y) : CW'(clip_y);
  assign mag_x = abs_x[MW-1:0];
  assign mag_y = abs_y[MW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      behind3 <= (clip_w < thr) || (clip_w <= '0);
      neg_x3  <= clip_x[CW-1];
      neg_y3  <= !clip_y[CW-1];
      den3    <= clip_w[MW-1:0];
      px_lo   <= mag_x[31:0] * size_w;
      px_hi   <= mag_x[MW-1:32] * size_w;
      py_lo   <= mag_y[31:0] * size_h;
      py_hi   <= mag_y[MW-1:32] * size_h;
    end
  end

  // stage 4: scaled dividend, overflow check and divider entry
  logic          v4, behind4, neg_x4, neg_y4;
  logic [MW-1:0] den4, rem_x4, rem_y4;
  logic [DB-1:0] low_x4, low_y4;
  logic          ovf_x4, ovf_y4;
  logic [NW-1:0] num_x, num_y;

  assign num_x = {NW'({px_hi, 32'b0}) + NW'(px_lo)} << 7;
  assign num_y = {NW'({py_hi, 32'b0}) + NW'(py_lo)} << 7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      behind4 <= behind3;
      neg_x4  <= neg_x3;
      neg_y4  <= neg_y3;
      den4    <= den3;
      ovf_x4  <= MW'(num_x[NW-1:DB]) >= den3;
      ovf_y4  <= MW'(num_y[NW-1:DB]) >= den3;
      rem_x4  <= MW'(num_x[NW-1:DB]);
      rem_y4  <= MW'(num_y[NW-1:DB]);
      low_x4  <= num_x[DB-1:0];
      low_y4  <= num_y[DB-1:0];
    end
  end

  // divider stages, one per axis
  logic [DB-1:0] quo_x, quo_y;
  logic          ovf_x, ovf_y;

  w2s_div u_div_x (
    .clk(clk), .en(en), .rem_in(rem_x4), .low_in(low_x4), .den_in(den4),
    .ovf_in(ovf_x4), .quo(quo_x), .ovf(ovf_x)
  );

  w2s_div u_div_y (
    .clk(clk), .en(en), .rem_in(rem_y4), .low_in(low_y4), .den_in(den4),
    .ovf_in(ovf_y4), .quo(quo_y), .ovf(ovf_y)
  );

  // sideband travelling alongside the divider
  logic vd [DB];
  logic bd [DB];
  logic nxd [DB];
  logic nyd [DB];

  for (genvar k = 0; k < DB; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        vd[k] <= 1'b0;
      end else if (en) begin
        vd[k] <= (k == 0) ? v4 : vd[(k == 0) ? 0 : k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        bd[k]  <= (k == 0) ? behind4 : bd[(k == 0) ? 0 : k-1];
        nxd[k] <= (k == 0) ? neg_x4  : nxd[(k == 0) ? 0 : k-1];
        nyd[k] <= (k == 0) ? neg_y4  : nyd[(k == 0) ? 0 : k-1];
      end
    end
  end

  // final stage: viewport offset and saturation
  function automatic logic signed [31:0] map_axis(
    input logic [15:0]   size,
    input logic [DB-1:0] q,
    input logic          neg,
    input logic          ovf
  );
    logic signed [DB+1:0] base;
    logic signed [DB+1:0] sum;
    base = $signed((DB+2)'({size, 7'b0}));
    sum  = neg ? base - $signed((DB+2)'(q)) : base + $signed((DB+2)'(q));
    if (ovf) begin
      map_axis = neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else if (sum > (DB+2)'(32'sh7FFF_FFFF)) begin
      map_axis = 32'sh7FFF_FFFF;
    end else if (sum < $signed((DB+2)'(32'sh8000_0000))) begin
      map_axis = 32'sh8000_0000;
    end else begin
      map_axis = sum[31:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vd[DB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word.behind_camera <= bd[DB-1];
      out_word.screen_x <= bd[DB-1] ? '0 : map_axis(size_w, quo_x, nxd[DB-1], ovf_x);
      out_word.screen_y <= bd[DB-1] ? '0 : map_axis(size_h, quo_y, nyd[DB-1], ovf_y);
    end
  end

  // checks
  a_behind_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.behind_camera |-> out_word.screen_x == 0 && out_word.screen_y == 0)
    else $error("behind-camera word with non-zero coordinates");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid straight after reset");

  a_zero_width: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.behind_camera && size_w == 16'd0 |-> out_word.screen_x == 0)
    else $error("zero viewport width gave non-zero x");

endmodule
`default_nettype wire

### sim/w2s_checker.sv
module w2s_checker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire w2s_pkg::in_word_t  in_word,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire w2s_pkg::out_word_t out_word,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [63:0]        cfg_data,
  output int                      fail_count,
  output int                      pending,
  output int                      seen_count,
  output int                      behind_count
);

  logic [63:0]        mat_col [3];
  logic [63:0]        trans_xy, trans_zw;
  logic [31:0]        view_size;
  logic [30:0]        near_w;
  w2s_pkg::out_word_t screen_q [$];

  function automatic longint coef_at(logic [63:0] col, int row);
    logic signed [15:0] c;
    c = col[16*row +: 16];
    return longint'(c);
  endfunction

  // floor(mag * scale / w), clamped well above the 32-bit range
  function automatic longint offset_div(longint mag, longint scale, longint w);
    logic [127:0] num, quo;
    num = 128'(mag) * 128'(scale);
    quo = num / 128'(w);
    if (quo > 128'(64'h1_0000_0000_00)) return 64'h1_0000_0000_01;
    return longint'(quo);
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [31:0] axis_pos(longint c, longint w, longint sz, bit flip);
    longint mag, q, base;
    bit neg;
    mag  = c < 0 ? -c : c;
    q    = offset_div(mag, sz << 7, w);
    neg  = (c < 0) != flip;
    base = sz * 128;
    return clamp32(neg ? base - q : base + q);
  endfunction

  function automatic w2s_pkg::out_word_t project(w2s_pkg::in_word_t p);
    longint px, py, pz, cx, cy, cw, thr;
    w2s_pkg::out_word_t r;
    px = longint'(p.pos_x);
    py = longint'(p.pos_y);
    pz = longint'(p.pos_z);
    cx = px * coef_at(mat_col[0], 0) + py * coef_at(mat_col[1], 0)
       + pz * coef_at(mat_col[2], 0) + longint'($signed(trans_xy[31:0])) * 8192;
    cy = px * coef_at(mat_col[0], 1) + py * coef_at(mat_col[1], 1)
       + pz * coef_at(mat_col[2], 1) + longint'($signed(trans_xy[63:32])) * 8192;
    cw = px * coef_at(mat_col[0], 3) + py * coef_at(mat_col[1], 3)
       + pz * coef_at(mat_col[2], 3) + longint'($signed(trans_zw[63:32])) * 8192;
    thr = longint'({33'd0, near_w}) << 13;
    r = '0;
    if (cw < thr || cw <= 0) begin
      r.behind_camera = 1'b1;
    end else begin
      r.screen_x = axis_pos(cx, cw, longint'(view_size[15:0]), 1'b0);
      r.screen_y = axis_pos(cy, cw, longint'(view_size[31:16]), 1'b1);
    end
    return r;
  endfunction

  // Register shadow, predictor and comparison
  always @(posedge clk) begin
    w2s_pkg::out_word_t exp_w;
    int errs;
    errs = 0;
    if (rst) begin
      mat_col[0] <= '0; mat_col[1] <= '0; mat_col[2] <= '0;
      trans_xy <= '0; trans_zw <= 64'd65536;
      view_size <= '0; near_w <= 31'd3277;
      screen_q.delete();
      fail_count <= 0; seen_count <= 0; behind_count <= 0;
    end else begin
      if (cfg_we) begin
        case (w2s_pkg::reg_index_t'(cfg_index))
          w2s_pkg::REG_MATRIX_COL0:  mat_col[0] <= cfg_data;
          w2s_pkg::REG_MATRIX_COL1:  mat_col[1] <= cfg_data;
          w2s_pkg::REG_MATRIX_COL2:  mat_col[2] <= cfg_data;
          w2s_pkg::REG_TRANSLATE_XY: trans_xy <= cfg_data;
          w2s_pkg::REG_TRANSLATE_ZW: trans_zw <= cfg_data;
          w2s_pkg::REG_SCREEN_SIZE:  view_size <= cfg_data[31:0];
          w2s_pkg::REG_NEAR_THRESH:  near_w <= cfg_data[30:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) screen_q.push_back(project(in_word));
      if (out_valid && !out_stall) begin
        seen_count <= seen_count + 1;
        if (out_word.behind_camera) behind_count <= behind_count + 1;
        if (screen_q.size() == 0) begin
          $error("unexpected word %h", out_word);
          errs++;
        end else begin
          exp_w = screen_q.pop_front();
          if (out_word.screen_x !== exp_w.screen_x) begin
            $error("screen_x expected %h actual %h", exp_w.screen_x, out_word.screen_x);
            errs++;
          end
          if (out_word.screen_y !== exp_w.screen_y) begin
            $error("screen_y expected %h actual %h", exp_w.screen_y, out_word.screen_y);
            errs++;
          end
          if (out_word.behind_camera !== exp_w.behind_camera) begin
            $error("behind_camera expected %b actual %b",
                   exp_w.behind_camera, out_word.behind_camera);
            errs++;
          end
        end
        fail_count <= fail_count + errs;
      end
    end
  end

  assign pending = screen_q.size();
endmodule

### sim/tb_world_to_screen_projection_core.sv
module tb_world_to_screen_projection_core;

  localparam int LATENCY    = 39;
  localparam int IDLE_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, in_stall;
  w2s_pkg::in_word_t in_word = '0;
  logic out_valid, out_stall = 1'b0;
  w2s_pkg::out_word_t out_word;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  int fail_count, pending, seen_count, behind_count;
  int idle_cycles = 0;
  bit gaps_on = 1'b1;
  bit hold_on = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  world_to_screen_projection_core u_dut (
    .clk, .rst, .in_valid, .in_stall, .in_word, .out_valid, .out_stall,
    .out_word, .cfg_we, .cfg_index, .cfg_data
  );

  w2s_checker u_check (
    .clk, .rst, .in_valid, .in_stall, .in_word, .out_valid, .out_stall,
    .out_word, .cfg_we, .cfg_index, .cfg_data, .fail_count, .pending,
    .seen_count, .behind_count
  );

  // Receiver: random stall bursts, or one long hold when asked
  initial begin
    int n;
    @(negedge clk);
    forever begin
      if (hold_on) begin
        out_stall <= 1'b1;
        repeat (150) @(negedge clk);
        out_stall <= 1'b0;
        hold_on = 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 5);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
      @(negedge clk);
    end
  end

  // Watchdog on handshake activity
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_reg(w2s_pkg::reg_index_t idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Offer one point, hold it until taken, then maybe leave a gap
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    int n;
    in_valid <= 1'b1;
    in_word <= '{pos_z: z, pos_y: y, pos_x: x};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      n = $urandom_range(1, 5);
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  function automatic logic [15:0] rand_coef();
    case ($urandom_range(0, 3))
      0: return 16'h2000;
      1: return 16'he000;
      2: return 16'($signed($urandom_range(0, 4096)) - 2048);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] rand_col();
    return {rand_coef(), rand_coef(), rand_coef(), rand_coef()};
  endfunction

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
      default: return 32'($signed($urandom_range(0, 400 << 16)) - (200 << 16));
    endcase
  endfunction

  // Camera-like matrix: identity-ish x/y, w driven by z
  task automatic camera_setup(logic [31:0] size, logic [30:0] near);
    write_reg(w2s_pkg::REG_MATRIX_COL0, {16'h0000, rand_coef(), 16'h0000, 16'h2000});
    write_reg(w2s_pkg::REG_MATRIX_COL1, {16'h0000, rand_coef(), 16'h2000, 16'h0000});
    write_reg(w2s_pkg::REG_MATRIX_COL2,
              {16'h2000, rand_coef(), 16'($urandom), 16'($urandom)});
    write_reg(w2s_pkg::REG_TRANSLATE_XY, {$urandom, $urandom});
    write_reg(w2s_pkg::REG_TRANSLATE_ZW, {32'($urandom_range(0, 8 << 16)), $urandom});
    write_reg(w2s_pkg::REG_SCREEN_SIZE, 64'(size));
    write_reg(w2s_pkg::REG_NEAR_THRESH, 64'(near));
  endtask

  initial begin
    logic [31:0] edge_vals [6];
    edge_vals = '{32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h0001_0000, 32'h1};
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset registers, then extremes of fields and registers
    send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    drain();
    write_reg(w2s_pkg::REG_MATRIX_COL0, 64'h7fff_8000_1234_7fff);
    write_reg(w2s_pkg::REG_MATRIX_COL1, 64'h8000_7fff_edcb_8000);
    write_reg(w2s_pkg::REG_MATRIX_COL2, 64'h0001_ffff_7fff_0001);
    write_reg(w2s_pkg::REG_TRANSLATE_XY, 64'h8000_0000_7fff_ffff);
    write_reg(w2s_pkg::REG_TRANSLATE_ZW, 64'h0000_0001_ffff_ffff);
    write_reg(w2s_pkg::REG_SCREEN_SIZE, 64'hffff_ffff);
    write_reg(w2s_pkg::REG_NEAR_THRESH, 64'h0);
    foreach (edge_vals[i]) send_point(edge_vals[i], edge_vals[(i + 1) % 6], edge_vals[(i + 2) % 6]);
    send_point(32'h0, 32'h0, 32'h0);
    drain();
    // w exactly at threshold, just under it, zero screen size, huge quotients
    write_reg(w2s_pkg::REG_MATRIX_COL0, 64'h0000_0000_0000_2000);
    write_reg(w2s_pkg::REG_MATRIX_COL1, 64'h0000_0000_2000_0000);
    write_reg(w2s_pkg::REG_MATRIX_COL2, 64'h2000_0000_0000_0000);
    write_reg(w2s_pkg::REG_TRANSLATE_XY, 64'h0);
    write_reg(w2s_pkg::REG_TRANSLATE_ZW, 64'h0);
    write_reg(w2s_pkg::REG_SCREEN_SIZE, 64'h0438_0780);
    write_reg(w2s_pkg::REG_NEAR_THRESH, 64'h7fff_ffff);
    send_point(32'h0001_0000, 32'h0001_0000, 32'h7fff_ffff);
    send_point(32'h0001_0000, 32'h0001_0000, 32'h7fff_fffe);
    drain();
    write_reg(w2s_pkg::REG_NEAR_THRESH, 64'd3277);
    send_point(32'h0001_0000, 32'hffff_0000, 32'd3277);
    send_point(32'h0001_0000, 32'hffff_0000, 32'd3276);
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'd3277);
    send_point(32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000);
    send_point(32'h0, 32'h0, 32'hffff_0000);
    drain();
    write_reg(w2s_pkg::REG_SCREEN_SIZE, 64'h0);
    send_point(32'h0003_0000, 32'hfffd_0000, 32'h0002_0000);
    drain();

    // Random phases over several camera settings
    for (int ph = 0; ph < 9; ph++) begin
      if (ph < 8) begin
        camera_setup(ph == 3 ? 32'hffff_ffff : {16'($urandom), 16'($urandom)},
                     ph == 5 ? 31'd0 : 31'($urandom_range(0, 1 << 17)));
      end else begin
        write_reg(w2s_pkg::REG_MATRIX_COL0, rand_col());
        write_reg(w2s_pkg::REG_MATRIX_COL1, rand_col());
        write_reg(w2s_pkg::REG_MATRIX_COL2, rand_col());
      end
      if (ph == 2) hold_on = 1'b1;
      if (ph == 7) gaps_on = 1'b0;
      repeat (100) send_point(rand_pos(), rand_pos(), rand_pos());
      drain();
    end

    $display("Covered %0d projected points, %0d of them rejected as behind the camera.",
             seen_count, behind_count);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
